FILE: rtl/ssm_pkg.sv
// shared types, constants and the cordic arctangent table for the shaped sine modulator
package ssm_pkg;

    localparam int unsigned TABLE_LEN = 24;
    localparam int unsigned REG_IDX_W = 2;
    localparam int unsigned SHARP_W   = 4;

    // cordic start value 0.6072529350 in q4.30
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // register indexes on the configuration port
    localparam logic [REG_IDX_W-1:0] REG_FREQUENCY = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SHARPNESS = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_ABS_MODE  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PHASE_MUL,
        S_FOLD,
        S_CORDIC,
        S_ROUND,
        S_SHAPE_MUL,
        S_SHAPE_UPD,
        S_SCALE_MUL,
        S_FINISH
    } t_state;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h2000_0000;
            5'd1:    val = 32'h12E4_051E;
            5'd2:    val = 32'h09FB_385B;
            5'd3:    val = 32'h0511_11D4;
            5'd4:    val = 32'h028B_0D43;
            5'd5:    val = 32'h0145_D7E1;
            5'd6:    val = 32'h00A2_F61E;
            5'd7:    val = 32'h0051_7C55;
            5'd8:    val = 32'h0028_BE53;
            5'd9:    val = 32'h0014_5F2F;
            5'd10:   val = 32'h000A_2F98;
            5'd11:   val = 32'h0005_17CC;
            5'd12:   val = 32'h0002_8BE6;
            5'd13:   val = 32'h0001_45F3;
            5'd14:   val = 32'h0000_A2FA;
            5'd15:   val = 32'h0000_517D;
            5'd16:   val = 32'h0000_28BE;
            5'd17:   val = 32'h0000_145F;
            5'd18:   val = 32'h0000_0A30;
            5'd19:   val = 32'h0000_0518;
            5'd20:   val = 32'h0000_028C;
            5'd21:   val = 32'h0000_0146;
            5'd22:   val = 32'h0000_00A3;
            5'd23:   val = 32'h0000_0051;
            default: val = 32'h0000_0000;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/shaped_sine_modulator_top.sv
// shaped sine modulator: cordic sine, with phase, power shaping and scaling on one shared multiplier
//
// usage: pulse start with time and base on the input ports while busy is low;
// that edge takes the transaction and busy goes high on the next cycle.
// the result appears on o_result_value, marked by o_result_strobe for
// exactly one cycle; the receiver cannot hold it off and must take it then.
// after the accepting edge the sequencer runs the phase multiply, the fold,
// the cordic loop at one rotation a cycle, the rounding, p - 1 shaping
// multiply and update pairs when the effective sharpness p is 2 or more,
// the amplitude scaling and the finish. the multiplies share the single
// 32 x 32 multiplier, used once for the phase, once per shaping power and
// once for the amplitude scaling, each use followed by a register stage.
// busy falls in the cycle the strobe is shown, so a new start may be taken
// in that same cycle; one transaction is in flight at a time.
// configuration writes (frequency, amplitude, sharpness, abs mode) land
// at the edge where i_cfg_we is high and belong in idle periods.
// a synchronous active-low reset returns the sequencer to idle, drops the
// strobe and loads the register reset values (1.0, 1.0, 0, 0).
module shaped_sine_modulator_top #(
    parameter int CORDIC_STEPS  = 16,
    parameter int MAX_SHARPNESS = 15
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [31:0]             i_time_value,
    input  logic signed [31:0]             i_base_value,
    input  logic                           i_cfg_we,
    input  logic [ssm_pkg::REG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    output logic                           o_result_strobe,
    output logic signed [31:0]             o_result_value
);
    import ssm_pkg::*;

    localparam int STEPS   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int CNT_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int P_CAP   = (MAX_SHARPNESS > 15) ? 15 : MAX_SHARPNESS;
    localparam logic [CNT_W-1:0]   LAST_STEP = CNT_W'(STEPS - 1);
    localparam logic [SHARP_W-1:0] SHARP_CAP = SHARP_W'(P_CAP);

    // configuration registers
    logic signed [31:0]   r_freq;
    logic signed [31:0]   r_amp;
    logic [SHARP_W-1:0]   r_sharp;
    logic                 r_abs;

    // sequencer and datapath registers
    t_state               r_state, n_state;
    logic signed [31:0]   r_time, r_base;
    logic signed [63:0]   r_prod;
    logic signed [33:0]   r_x, r_y, r_z, n_x, n_y, n_z;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [14:0]          r_m, n_m, r_v, n_v;
    logic                 r_neg, n_neg;
    logic [SHARP_W-1:0]   r_p, n_p, r_k, n_k;
    logic                 r_strobe, n_strobe;
    logic signed [31:0]   r_result, n_result;

    // shared multiplier operands
    logic signed [31:0]   mul_a, mul_b;

    // combinational helpers
    logic signed [33:0]   phase_s, fold;
    logic signed [33:0]   dx, dy, atan_s;
    logic signed [18:0]   y_rnd;
    logic signed [15:0]   sine;
    logic [SHARP_W-1:0]   p_eff;
    logic signed [16:0]   shaped;
    logic signed [63:0]   prod_rnd;
    logic signed [49:0]   sum;
    logic signed [31:0]   sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq  <= 32'sd65536;
            r_amp   <= 32'sd65536;
            r_sharp <= '0;
            r_abs   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FREQUENCY: r_freq  <= i_cfg_data;
                REG_AMPLITUDE: r_amp   <= i_cfg_data;
                REG_SHARPNESS: r_sharp <= i_cfg_data[SHARP_W-1:0];
                REG_ABS_MODE:  r_abs   <= i_cfg_data[0];
                default:       r_abs   <= r_abs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_time <= i_time_value;
            r_base <= i_base_value;
        end
        r_prod   <= 64'(mul_a) * 64'(mul_b);
        r_x      <= n_x;
        r_y      <= n_y;
        r_z      <= n_z;
        r_cnt    <= n_cnt;
        r_m      <= n_m;
        r_v      <= n_v;
        r_neg    <= n_neg;
        r_p      <= n_p;
        r_k      <= n_k;
        r_result <= n_result;
    end

    always_comb begin
        // phase fold into a quarter turn about zero
        phase_s = 34'(signed'(r_prod[31:0]));
        if (phase_s > 34'sh0_4000_0000) begin
            fold = 34'sh0_8000_0000 - phase_s;
        end else if (phase_s < -34'sh0_4000_0000) begin
            fold = -34'sh0_8000_0000 - phase_s;
        end else begin
            fold = phase_s;
        end

        // one cordic rotation
        dx     = r_y >>> r_cnt;
        dy     = r_x >>> r_cnt;
        atan_s = 34'(signed'({1'b0, atan_turn(5'(r_cnt))}));

        // sine rounded half up to q1.15 and clamped
        y_rnd = 19'((r_y + 34'sd16384) >>> 15);
        if (y_rnd > 19'sd32767) begin
            sine = 16'sd32767;
        end else if (y_rnd < -19'sd32767) begin
            sine = -16'sd32767;
        end else begin
            sine = 16'(y_rnd);
        end

        p_eff  = (r_sharp > SHARP_CAP) ? SHARP_CAP : r_sharp;
        shaped = (r_neg && !r_abs) ? -$signed({2'b00, r_v}) : $signed({2'b00, r_v});

        // amplitude scaling, round half up, offset and clamp
        prod_rnd = r_prod + 64'sd16384;
        sum      = 50'(prod_rnd >>> 15) + 50'(r_base);
        if (sum > 50'sd2147483647) begin
            sat = 32'sh7FFF_FFFF;
        end else if (sum < -50'sd2147483648) begin
            sat = 32'sh8000_0000;
        end else begin
            sat = 32'(sum);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_y      = r_y;
        n_z      = r_z;
        n_cnt    = r_cnt;
        n_m      = r_m;
        n_v      = r_v;
        n_neg    = r_neg;
        n_p      = r_p;
        n_k      = r_k;
        n_strobe = 1'b0;
        n_result = r_result;
        mul_a    = '0;
        mul_b    = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_PHASE_MUL;
                end
            end
            S_PHASE_MUL: begin
                mul_a   = r_time;
                mul_b   = r_freq;
                n_state = S_FOLD;
            end
            S_FOLD: begin
                n_x     = CORDIC_GAIN_Q30;
                n_y     = '0;
                n_z     = fold;
                n_cnt   = '0;
                n_state = S_CORDIC;
            end
            S_CORDIC: begin
                if (!r_z[33]) begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_z = r_z - atan_s;
                end else begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_z = r_z + atan_s;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_neg = sine[15];
                n_m   = sine[15] ? 15'(-sine) : 15'(sine);
                n_v   = n_m;
                n_p   = p_eff;
                n_k   = SHARP_W'(1);
                n_state = (p_eff > SHARP_W'(1)) ? S_SHAPE_MUL : S_SCALE_MUL;
            end
            S_SHAPE_MUL: begin
                mul_a   = 32'({17'b0, r_v});
                mul_b   = 32'({17'b0, r_m});
                n_state = S_SHAPE_UPD;
            end
            S_SHAPE_UPD: begin
                n_v = prod_rnd[29:15];
                n_k = r_k + 1'b1;
                n_state = (n_k >= r_p) ? S_SCALE_MUL : S_SHAPE_MUL;
            end
            S_SCALE_MUL: begin
                mul_a   = 32'(shaped);
                mul_b   = r_amp;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                n_result = sat;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_result_value  = r_result;

endmodule

FILE: rtl/ssm_checker.sv
// port-level checks on the shaped sine modulator, bound to the top level
module ssm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_result_strobe
);

    // a result only ends a transaction that was in progress
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    // an accepted transaction makes the block busy, with no result strobe
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_result_strobe))
        else $error("transaction accepted but block not busy");

    // busy only drops together with a result
    a_busy_end_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_result_strobe)
        else $error("busy dropped without a result");

    // one result per transaction, never two in a row
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe held for more than one cycle");

endmodule

bind shaped_sine_modulator_top ssm_checker u_ssm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe)
);

FILE: dv/testbench.sv
// self-checking testbench for the shaped sine modulator: command port, config writes, scoreboard
`timescale 1ns / 100ps

module testbench;
    import ssm_pkg::*;

    localparam int CORDIC_STEPS  = 16;
    localparam int MAX_SHARPNESS = 15;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int TAIL_CYCLES   = 60;

    localparam longint QUARTER_TURN = 64'sd1073741824;
    localparam longint HALF_TURN    = 64'sd2147483648;
    localparam longint GAIN_Q30     = 64'sd652032874;

    typedef enum logic [1:0] {
        OP_ITEM,
        OP_WRITE,
        OP_DRAIN
    } t_op_kind;

    typedef struct {
        t_op_kind                kind;
        logic [31:0]             a;
        logic [31:0]             b;
        logic [REG_IDX_W-1:0]    idx;
        int                      idle_pct;
    } t_op;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [31:0]           i_time_value = '0;
    logic [31:0]           i_base_value = '0;
    logic                  i_cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]  i_cfg_index = '0;
    logic [31:0]           i_cfg_data = '0;
    logic                  o_result_strobe;
    logic [31:0]           o_result_value;

    // shadow copy of the configuration registers
    logic [31:0]        freq_q = 32'h0001_0000;
    logic [31:0]        amp_q = 32'h0001_0000;
    logic [SHARP_W-1:0] sharp_q = '0;
    logic               abs_q = 1'b0;

    longint arctan_tbl [0:23] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    t_op         pending_ops [$];
    logic [31:0] modulated_q [$];
    int          errors = 0;
    int          cycle_cnt = 0;

    shaped_sine_modulator_top #(
        .CORDIC_STEPS  (CORDIC_STEPS),
        .MAX_SHARPNESS (MAX_SHARPNESS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_time_value    (i_time_value),
        .i_base_value    (i_base_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_result_value  (o_result_value)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int cordic_sine_q15(logic [31:0] phase);
        longint ang, x, y, z, dx, dy;
        ang = longint'($signed(phase));
        // fold into a quarter turn about zero, sine is symmetric about the quarter
        if (ang > QUARTER_TURN)
            ang = HALF_TURN - ang;
        else if (ang < -QUARTER_TURN)
            ang = -HALF_TURN - ang;
        x = GAIN_Q30;
        y = 0;
        z = ang;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_tbl[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_tbl[i];
            end
        end
        y = (y + 16384) >>> 15;
        if (y > 32767)
            y = 32767;
        if (y < -32767)
            y = -32767;
        return int'(y);
    endfunction

    function automatic logic [31:0] predict_modulated(logic [31:0] tval, logic [31:0] bval);
        longint      prod, sine, mag, shaped, r;
        int unsigned pw;
        bit          neg;
        prod = longint'($signed(tval)) * longint'($signed(freq_q));
        sine = longint'(cordic_sine_q15(32'(prod)));
        neg = sine < 0;
        mag = neg ? -sine : sine;
        pw = sharp_q;
        if (pw > MAX_SHARPNESS)
            pw = MAX_SHARPNESS;
        if (pw > 0) begin
            shaped = mag;
            for (int unsigned k = 1; k < pw; k++)
                shaped = (shaped * mag + 16384) >>> 15;
            mag = shaped;
        end
        if (abs_q)
            neg = 1'b0;
        sine = neg ? -mag : mag;
        r = longint'($signed(bval)) + ((sine * longint'($signed(amp_q)) + 16384) >>> 15);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return 32'(r);
    endfunction

    // full-range words, extremes and small signed values in equal shares
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        case ($urandom_range(5))
            0: w = 32'h7FFF_FFFF;
            1: w = 32'h8000_0000;
            2, 3: begin
                w = $urandom_range(0, 262143);
                if ($urandom_range(1) == 1)
                    w = -w;
            end
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic add_item(logic [31:0] tval, logic [31:0] bval, int pct);
        t_op op;
        op.kind = OP_ITEM;
        op.a = tval;
        op.b = bval;
        op.idx = '0;
        op.idle_pct = pct;
        pending_ops.push_back(op);
    endtask

    // every write waits for the block to drain first
    task automatic add_write(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
        t_op op;
        op.kind = OP_DRAIN;
        op.a = '0;
        op.b = '0;
        op.idx = '0;
        op.idle_pct = 0;
        pending_ops.push_back(op);
        op.kind = OP_WRITE;
        op.a = data;
        op.idx = idx;
        pending_ops.push_back(op);
    endtask

    // driver: issues queued operations and predicts each accepted transaction
    always @(posedge i_clk) begin
        t_op  head;
        logic start_nx, we_nx;
        start_nx = start;
        we_nx = 1'b0;
        if (!i_rst_n) begin
            start_nx = 1'b0;
            freq_q = 32'h0001_0000;
            amp_q = 32'h0001_0000;
            sharp_q = '0;
            abs_q = 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FREQUENCY: freq_q = i_cfg_data;
                    REG_AMPLITUDE: amp_q = i_cfg_data;
                    REG_SHARPNESS: sharp_q = i_cfg_data[SHARP_W-1:0];
                    REG_ABS_MODE:  abs_q = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                modulated_q.push_back(predict_modulated(i_time_value, i_base_value));
                start_nx = 1'b0;
            end
            if (!start_nx && pending_ops.size() > 0) begin
                head = pending_ops[0];
                case (head.kind)
                    OP_ITEM: begin
                        if ($urandom_range(99) >= head.idle_pct) begin
                            i_time_value <= head.a;
                            i_base_value <= head.b;
                            start_nx = 1'b1;
                            void'(pending_ops.pop_front());
                        end
                    end
                    OP_WRITE: begin
                        i_cfg_index <= head.idx;
                        i_cfg_data <= head.a;
                        we_nx = 1'b1;
                        void'(pending_ops.pop_front());
                    end
                    OP_DRAIN: begin
                        // strobe low means the monitor does not pop at this edge
                        if (modulated_q.size() == 0 && !busy && !o_result_strobe && !i_cfg_we)
                            void'(pending_ops.pop_front());
                    end
                    default: ;
                endcase
            end
        end
        start <= start_nx;
        i_cfg_we <= we_nx;
    end

    // monitor: each strobe carries one result, compared with the oldest prediction
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_result_strobe) begin
            if (modulated_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_result_value);
            end else begin
                want = modulated_q.pop_front();
                if (o_result_value !== want) begin
                    errors++;
                    $display("%0t: result_value mismatch, expected %h, actual %h",
                             $time, want, o_result_value);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        int sender_pct [3] = '{37, 50, 0};
        int pct;

        // reset settings: zero, quarter, half and three-quarter turns and both saturations
        add_item(32'h0000_0000, 32'h0000_0000, 37);
        add_item(32'h0000_4000, 32'h0000_0000, 37);
        add_item(32'h0000_C000, 32'h0000_0000, 37);
        add_item(32'h0000_8000, 32'h1234_5678, 37);
        add_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 37);
        add_item(32'h8000_0000, 32'h8000_0000, 37);
        add_item(32'h0000_2000, 32'h7FFF_FFFF, 37);
        add_item(32'h0000_E000, 32'h8000_0000, 37);

        // top extremes, sharpness one passes the sine, upper data bits ignored
        add_write(REG_FREQUENCY, 32'h7FFF_FFFF);
        add_write(REG_AMPLITUDE, 32'h7FFF_FFFF);
        add_write(REG_SHARPNESS, 32'hFFFF_FFF1);
        add_write(REG_ABS_MODE, 32'h0000_0001);
        add_item(32'hFFFF_FFFF, 32'h0000_0000, 37);
        add_item(32'h0001_2345, 32'h8000_0000, 37);
        add_item(32'h8000_0000, 32'h0000_0000, 37);
        add_item(32'h0000_4000, 32'h7FFF_FFFF, 37);

        // bottom extremes with the deepest shaping
        add_write(REG_FREQUENCY, 32'h8000_0000);
        add_write(REG_AMPLITUDE, 32'h8000_0000);
        add_write(REG_SHARPNESS, 32'h0000_000F);
        add_write(REG_ABS_MODE, 32'hFFFF_FFFE);
        add_item(32'h0000_0001, 32'h0000_0000, 37);
        add_item(32'h0000_0002, 32'h7FFF_FFFF, 37);

        add_write(REG_FREQUENCY, 32'h0001_0000);
        add_item(32'h0000_4000, 32'h0000_0000, 37);
        add_item(32'h0000_C000, 32'h8000_0000, 37);
        add_item(32'h0000_0000, 32'h0000_1000, 37);
        add_write(REG_SHARPNESS, 32'h0000_0002);
        add_write(REG_ABS_MODE, 32'h0000_0001);
        add_item(32'h0000_C000, 32'h0000_0000, 37);
        add_item(32'h0000_3000, 32'h8000_0000, 37);

        // random settings, each followed by a burst of random transactions
        for (int ph = 0; ph < 3; ph++) begin
            pct = sender_pct[ph];
            for (int st = 0; st < 4; st++) begin
                add_write(REG_FREQUENCY, pick_word());
                add_write(REG_AMPLITUDE, pick_word());
                add_write(REG_SHARPNESS, $urandom);
                add_write(REG_ABS_MODE, $urandom);
                for (int n = 0; n < 55; n++)
                    add_item(($urandom_range(1) == 1) ? $urandom : pick_word(),
                             pick_word(), pct);
            end
        end

        @(posedge i_clk);
        while (!i_rst_n || pending_ops.size() != 0 || start || modulated_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && modulated_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

endmodule
